/* rtl/ledscan_pkg.sv */
// ----------------------------------------------------------------------------
// ledscan_pkg
// Shared types and constants of the LED matrix row scanner (5 x 7 matrix).
// ----------------------------------------------------------------------------
package ledscan_pkg;

    // matrix geometry
    localparam int COLUMNS          = 5;
    localparam int ROWS             = 7;
    localparam int ROW_W            = 3;   // bits of a row index
    localparam int GLYPH_COL_W      = 7;   // bits of one glyph column
    localparam int BLINK_W          = 12;  // blink counter width
    localparam int BLANK_W          = 4;   // blank row counter width
    localparam int FREEZE_BIT       = 3;   // blank count >= 8 once this bit is set

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // input tdata / tuser layout
    localparam int IN_TDATA_W       = 40;  // 5 x 7 bits, padded to bytes
    localparam int IN_TUSER_W       = 2;
    localparam int OUT_TDATA_W      = 16;  // 7 + 5 bits, padded to bytes
    localparam int OUT_TUSER_W      = 1;

    // configuration port
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 8;

    typedef logic [COLUMNS-1:0] t_row_bits;

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_ACTIVE_LEVEL    = 3'd0,
        REG_COLUMN_ACTIVE_LEVEL = 3'd1,
        REG_BLINK_ON_FRAMES     = 3'd2,
        REG_BLINK_OFF_FRAMES    = 3'd3,
        REG_UPSIDE_DOWN         = 3'd4
    } t_cfg_reg;

endpackage

/* rtl/led_matrix_row_scanner_unit.sv */
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_unit
// Row multiplexer for a 5 x 7 LED matrix: glyph load and transpose, row scan,
// blink schedule, blank counting with freeze, row/column drive polarity.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | glyph columns, mode, space flag
//  m_axis   | out       | m_axis_tvalid/tready    | row lines, column lines, frozen
//  cfg      | in        | i_cfg_valid/o_cfg_ready | register index, write data
//
//  State updates at the edge that accepts an item, and a tick's result lands in
//  the output register on that same edge.
//  One item per cycle is sustained; s_axis_tready drops only while the output
//  register holds a result that m_axis_tready has not taken.
//  Load items produce no result. Configuration writes are always accepted.
//  Synchronous active-low reset clears all control and frame state.
//
module led_matrix_row_scanner_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [6:0] glyph_col_0, [13:7] glyph_col_1, [20:14] glyph_col_2,
    // [27:21] glyph_col_3, [34:28] glyph_col_4, [39:35] zero
    input  logic [ledscan_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode, [1] glyph_is_space
    input  logic [ledscan_pkg::IN_TUSER_W-1:0]  s_axis_tuser,

    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [6:0] row_lines, [11:7] column_lines, [15:12] zero
    output logic [ledscan_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] frozen
    output logic [ledscan_pkg::OUT_TUSER_W-1:0] m_axis_tuser,

    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ledscan_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ledscan_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = ledscan_pkg::COLUMNS;
    localparam int RW = ledscan_pkg::ROWS;
    localparam int GW = ledscan_pkg::GLYPH_COL_W;
    localparam int BW = ledscan_pkg::BLINK_W;
    localparam int NW = ledscan_pkg::BLANK_W;
    localparam int SW = ledscan_pkg::ROW_W;

    // configuration registers
    logic           r_row_level;
    logic           r_col_level;
    logic [7:0]     r_on_frames;
    logic [7:0]     r_off_frames;
    logic           r_upside_down;

    // scanner state
    ledscan_pkg::t_row_bits r_frame [RW];
    ledscan_pkg::t_row_bits n_frame [RW];
    logic [SW-1:0]  r_scan_row,   n_scan_row;
    logic [BW-1:0]  r_blink_cnt,  n_blink_cnt;
    logic [NW-1:0]  r_blank_cnt,  n_blank_cnt;
    logic [RW-1:0]  r_held_rows,  n_held_rows;
    logic [CW-1:0]  r_held_cols,  n_held_cols;

    // output register
    logic           r_out_valid;
    logic [RW-1:0]  r_out_rows;
    logic [CW-1:0]  r_out_cols;
    logic           r_out_frozen;
    logic           n_out_frozen;

    // combinational helpers
    logic                   w_accept;
    logic                   w_is_load;
    logic                   w_is_space;
    logic                   w_frozen;
    logic [GW-1:0]          w_glyph [CW];
    logic [RW-1:0]          w_old_mask;
    logic [RW-1:0]          w_new_mask;
    logic [RW-1:0]          w_rows_off;
    logic                   w_blink_en;
    logic [BW-1:0]          w_on_ticks;
    logic [8:0]             w_sum_frames;
    logic [BW-1:0]          w_period;
    logic [BW-1:0]          w_blink_step;
    logic                   w_show;
    ledscan_pkg::t_row_bits w_pat;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_is_load  = (ledscan_pkg::t_mode'(s_axis_tuser[0]) == ledscan_pkg::MODE_LOAD);
    assign w_is_space = s_axis_tuser[1];
    assign w_frozen   = r_blank_cnt[ledscan_pkg::FREEZE_BIT];

    // unpack glyph columns
    always_comb begin
        for (int c = 0; c < CW; c++) begin
            w_glyph[c] = s_axis_tdata[c*GW +: GW];
        end
    end

    // blink schedule figures: on * 7 and (on + off) * 7
    assign w_blink_en   = (r_on_frames != 8'd0) && (r_off_frames != 8'd0);
    assign w_on_ticks   = BW'({r_on_frames, 3'b000}) - BW'(r_on_frames);
    assign w_sum_frames = 9'(r_on_frames) + 9'(r_off_frames);
    assign w_period     = BW'({w_sum_frames, 3'b000}) - BW'(w_sum_frames);

    // row masks for the row being left and the row being entered
    assign w_old_mask = RW'(1) << r_scan_row;
    assign w_new_mask = RW'(1) << n_scan_row;

    // next state
    always_comb begin
        for (int r = 0; r < RW; r++) begin
            n_frame[r] = r_frame[r];
        end
        n_scan_row   = r_scan_row;
        n_blink_cnt  = r_blink_cnt;
        n_blank_cnt  = r_blank_cnt;
        n_held_rows  = r_held_rows;
        n_held_cols  = r_held_cols;
        n_out_frozen = 1'b0;
        w_blink_step = r_blink_cnt;
        w_show       = 1'b1;
        w_pat        = '0;
        w_rows_off   = r_held_rows;

        // row advance with wrap
        if (r_scan_row >= ledscan_pkg::LAST_ROW) begin
            n_scan_row = '0;
        end else begin
            n_scan_row = r_scan_row + SW'(1);
        end

        if (w_is_load) begin
            n_scan_row = r_scan_row;
            // transpose, mirrored in both axes when upside down
            for (int r = 0; r < RW; r++) begin
                for (int c = 0; c < CW; c++) begin
                    if (r_upside_down) begin
                        n_frame[r][c] = w_glyph[CW-1-c][RW-1-r];
                    end else begin
                        n_frame[r][c] = w_glyph[c][r];
                    end
                end
            end
            // space arms blank counting, any other glyph clears it
            if (w_is_space) begin
                if (r_blank_cnt == '0) begin
                    n_blank_cnt = NW'(1);
                end
            end else begin
                n_blank_cnt = '0;
            end
        end else if (w_frozen) begin
            n_scan_row   = r_scan_row;
            n_out_frozen = 1'b1;
        end else begin
            // previous row line to inactive
            if (r_row_level) begin
                w_rows_off = r_held_rows & ~w_old_mask;
            end else begin
                w_rows_off = r_held_rows | w_old_mask;
            end

            // blink phase
            if (w_blink_en) begin
                w_show       = (r_blink_cnt < w_on_ticks);
                w_blink_step = r_blink_cnt + BW'(1);
            end
            if (w_show) begin
                w_pat = r_frame[n_scan_row];
                if ((r_blank_cnt != '0) && (w_pat == '0)) begin
                    n_blank_cnt = r_blank_cnt + NW'(1);
                end
            end
            if (w_blink_step >= w_period) begin
                n_blink_cnt = '0;
            end else begin
                n_blink_cnt = w_blink_step;
            end

            // column drive
            n_held_cols = r_col_level ? w_pat : ~w_pat;

            // new row line to active
            if (r_row_level) begin
                n_held_rows = w_rows_off | w_new_mask;
            end else begin
                n_held_rows = w_rows_off & ~w_new_mask;
            end
        end
    end

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_level   <= 1'b1;
            r_col_level   <= 1'b1;
            r_on_frames   <= '0;
            r_off_frames  <= '0;
            r_upside_down <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ledscan_pkg::t_cfg_reg'(i_cfg_index))
                ledscan_pkg::REG_ROW_ACTIVE_LEVEL:    r_row_level   <= i_cfg_data[0];
                ledscan_pkg::REG_COLUMN_ACTIVE_LEVEL: r_col_level   <= i_cfg_data[0];
                ledscan_pkg::REG_BLINK_ON_FRAMES:     r_on_frames   <= i_cfg_data;
                ledscan_pkg::REG_BLINK_OFF_FRAMES:    r_off_frames  <= i_cfg_data;
                ledscan_pkg::REG_UPSIDE_DOWN:         r_upside_down <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // scanner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < RW; r++) begin
                r_frame[r] <= '0;
            end
            r_scan_row  <= '0;
            r_blink_cnt <= '0;
            r_blank_cnt <= '0;
            r_held_rows <= '0;
            r_held_cols <= '0;
        end else if (w_accept) begin
            for (int r = 0; r < RW; r++) begin
                r_frame[r] <= n_frame[r];
            end
            r_scan_row  <= n_scan_row;
            r_blink_cnt <= n_blink_cnt;
            r_blank_cnt <= n_blank_cnt;
            r_held_rows <= n_held_rows;
            r_held_cols <= n_held_cols;
        end
    end

    // output register: filled by each tick, freed when taken
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && !w_is_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_load) begin
            r_out_rows   <= n_held_rows;
            r_out_cols   <= n_held_cols;
            r_out_frozen <= n_out_frozen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(ledscan_pkg::OUT_TDATA_W - RW - CW)'(0), r_out_cols, r_out_rows};
    assign m_axis_tuser  = r_out_frozen;

endmodule

/* tb/led_matrix_row_scanner_unit_tb.sv */
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_unit_tb
// Self-checking bench for the 5 x 7 LED row scanner. A scoreboard class keeps
// its own copy of the frame store, scan row, blink and blank counters and
// predicts the row/column drive of every tick. Stimulus runs a directed
// opening, then phases of random glyph loads and ticks under changing drive
// polarity, blink periods and orientation, with random source gaps and sink
// stalls, one long sink hold-off and a source pause until drained.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS         = ledscan_pkg::COLUMNS;
    localparam int ROWS            = ledscan_pkg::ROWS;
    localparam int ROW_W           = ledscan_pkg::ROW_W;
    localparam int GLYPH_COL_W     = ledscan_pkg::GLYPH_COL_W;
    localparam int BLINK_W         = ledscan_pkg::BLINK_W;
    localparam int BLANK_W         = ledscan_pkg::BLANK_W;
    localparam int IN_TDATA_W      = ledscan_pkg::IN_TDATA_W;
    localparam int IN_TUSER_W      = ledscan_pkg::IN_TUSER_W;
    localparam int OUT_TDATA_W     = ledscan_pkg::OUT_TDATA_W;
    localparam int OUT_TUSER_W     = ledscan_pkg::OUT_TUSER_W;
    localparam int CFG_INDEX_W     = ledscan_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W      = ledscan_pkg::CFG_DATA_W;

    localparam int BLANK_LIMIT     = 8;
    localparam int TICKS_PER_FRAME = 7;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 108;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 500000;

    // one row/column drive result
    typedef struct packed {
        bit [ROWS-1:0]    row_lines;
        bit [COLUMNS-1:0] column_lines;
        bit               frozen;
    } t_drive;

    // ------------------------------------------------------------------------
    // Scoreboard: scanner prediction and result compare
    // ------------------------------------------------------------------------
    class scan_scoreboard;
        bit            row_level;
        bit            col_level;
        bit [7:0]      on_frames;
        bit [7:0]      off_frames;
        bit            flip;
        ledscan_pkg::t_row_bits frame[ROWS];
        bit [ROW_W-1:0] scan_row;
        bit [BLINK_W-1:0] blink_cnt;
        bit [BLANK_W-1:0] blank_cnt;
        bit [ROWS-1:0]    held_rows;
        bit [COLUMNS-1:0] held_cols;
        t_drive        expected_drive[$];
        int            errors;

        function new();
            row_level  = 1'b1;
            col_level  = 1'b1;
            on_frames  = '0;
            off_frames = '0;
            flip       = 1'b0;
            foreach (frame[r]) frame[r] = '0;
            scan_row   = '0;
            blink_cnt  = '0;
            blank_cnt  = '0;
            held_rows  = '0;
            held_cols  = '0;
            errors     = 0;
        endfunction

        function void set_reg(ledscan_pkg::t_cfg_reg idx, bit [7:0] val);
            case (idx)
                ledscan_pkg::REG_ROW_ACTIVE_LEVEL:    row_level  = val[0];
                ledscan_pkg::REG_COLUMN_ACTIVE_LEVEL: col_level  = val[0];
                ledscan_pkg::REG_BLINK_ON_FRAMES:     on_frames  = val;
                ledscan_pkg::REG_BLINK_OFF_FRAMES:    off_frames = val;
                ledscan_pkg::REG_UPSIDE_DOWN:         flip       = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction

        // accepted input transaction: update state, queue the tick's drive
        function void note_item(logic [IN_TDATA_W-1:0] data, logic [IN_TUSER_W-1:0] user);
            bit [GLYPH_COL_W-1:0] g[COLUMNS];
            ledscan_pkg::t_row_bits bits;
            ledscan_pkg::t_row_bits pat;
            bit [COLUMNS-1:0] cols;
            int unsigned on_ticks;
            int unsigned period;
            bit show;
            t_drive d;

            if (ledscan_pkg::t_mode'(user[0]) == ledscan_pkg::MODE_LOAD) begin
                for (int c = 0; c < COLUMNS; c++) g[c] = data[GLYPH_COL_W*c +: GLYPH_COL_W];
                // transpose into rows, mirrored in both axes when flipped
                for (int r = 0; r < ROWS; r++) begin
                    bits = '0;
                    for (int c = 0; c < COLUMNS; c++)
                        bits[c] = flip ? g[COLUMNS-1-c][ROWS-1-r] : g[c][r];
                    frame[r] = bits;
                end
                if (user[1]) begin
                    if (blank_cnt == 0) blank_cnt = 1;
                end else begin
                    blank_cnt = '0;
                end
                return;
            end

            // frozen: repeat the held drive
            if (blank_cnt >= BLANK_LIMIT) begin
                d.row_lines    = held_rows;
                d.column_lines = held_cols;
                d.frozen       = 1'b1;
                expected_drive.push_back(d);
                return;
            end

            held_rows[scan_row] = ~row_level;
            scan_row = (scan_row >= ROWS - 1) ? '0 : scan_row + 1'b1;

            on_ticks = on_frames * TICKS_PER_FRAME;
            period   = (on_frames + off_frames) * TICKS_PER_FRAME;
            if (on_frames == 0 || off_frames == 0) begin
                show = 1'b1;
            end else begin
                show = blink_cnt < on_ticks;
                blink_cnt = blink_cnt + 1'b1;
            end
            if (show) begin
                pat = frame[scan_row];
                if (blank_cnt != 0 && pat == 0) blank_cnt = blank_cnt + 1'b1;
            end else begin
                pat = '0;
            end
            if (blink_cnt >= period) blink_cnt = '0;

            for (int c = 0; c < COLUMNS; c++) cols[c] = pat[c] ? col_level : ~col_level;
            held_cols = cols;
            held_rows[scan_row] = row_level;

            d.row_lines    = held_rows;
            d.column_lines = held_cols;
            d.frozen       = 1'b0;
            expected_drive.push_back(d);
        endfunction

        // accepted output transaction: compare with the oldest prediction
        function void check_drive(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
            t_drive d;
            if (expected_drive.size() == 0) begin
                $display("%0t: unexpected result row_lines=%h column_lines=%h frozen=%b",
                         $time, data[6:0], data[11:7], user[0]);
                errors++;
                return;
            end
            d = expected_drive.pop_front();
            if (data[6:0] !== d.row_lines) begin
                $display("%0t: row_lines expected %h actual %h", $time, d.row_lines, data[6:0]);
                errors++;
            end
            if (data[11:7] !== d.column_lines) begin
                $display("%0t: column_lines expected %h actual %h",
                         $time, d.column_lines, data[11:7]);
                errors++;
            end
            if (user[0] !== d.frozen) begin
                $display("%0t: frozen expected %b actual %b", $time, d.frozen, user[0]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data     = '0;

    led_matrix_row_scanner_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    scan_scoreboard sb = new();
    int  tx_gap_pct   = 0;
    int  rx_stall_pct = 0;
    bit  hold_req     = 1'b0;
    int  cycles       = 0;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // monitors: both streams sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata, s_axis_tuser);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_drive(m_axis_tdata, m_axis_tuser);
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // sink: random stalls plus the long hold-off on request
    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_axis_tready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_item(ledscan_pkg::t_mode m, bit [COLUMNS*GLYPH_COL_W-1:0] cols, bit sp);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, cols};
        s_axis_tuser  <= {sp, m};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(ledscan_pkg::MODE_TICK, 35'({$urandom(), $urandom()}),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_item();
        bit [COLUMNS*GLYPH_COL_W-1:0] cols;
        bit [GLYPH_COL_W-1:0] keep;
        bit sp;
        cols = 35'({$urandom(), $urandom()});
        if ($urandom_range(0, 99) < 22) begin
            sp = ($urandom_range(0, 99) < 35);
            if (sp && $urandom_range(0, 1)) begin
                cols = '0;
            end else if ($urandom_range(0, 1)) begin
                // blank out some rows so that dark rows occur
                keep = 7'($urandom());
                for (int k = 0; k < COLUMNS; k++) cols[GLYPH_COL_W*k +: GLYPH_COL_W] &= keep;
            end
            send_item(ledscan_pkg::MODE_LOAD, cols, sp);
        end else begin
            send_tick();
        end
    endtask

    // stop sending and wait until every predicted drive has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(ledscan_pkg::t_cfg_reg idx, bit [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_config(bit rl, bit cl, bit [7:0] on_f, bit [7:0] off_f, bit ud);
        write_cfg(ledscan_pkg::REG_ROW_ACTIVE_LEVEL, {7'($urandom()), rl});
        write_cfg(ledscan_pkg::REG_COLUMN_ACTIVE_LEVEL, {7'($urandom()), cl});
        write_cfg(ledscan_pkg::REG_BLINK_ON_FRAMES, on_f);
        write_cfg(ledscan_pkg::REG_BLINK_OFF_FRAMES, off_f);
        write_cfg(ledscan_pkg::REG_UPSIDE_DOWN, {7'($urandom()), ud});
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        bit rl, cl, ud;
        bit [7:0] on_f, off_f;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening at reset settings, no idling
        send_tick();
        send_item(ledscan_pkg::MODE_LOAD, {5{7'h7F}}, 1'b0);
        repeat (2) send_tick();
        send_item(ledscan_pkg::MODE_LOAD, {7'h41, 7'h00, 7'h7F, 7'h2A, 7'h55}, 1'b0);
        repeat (3) send_tick();
        // blank glyph arms counting, seven dark rows freeze the scan
        send_item(ledscan_pkg::MODE_LOAD, '0, 1'b1);
        repeat (8) send_tick();
        // space load while frozen keeps the count
        send_item(ledscan_pkg::MODE_LOAD, {5{7'h7F}}, 1'b1);
        send_tick();
        // non-space load unfreezes
        send_item(ledscan_pkg::MODE_LOAD, {7'h01, 7'h02, 7'h04, 7'h08, 7'h40}, 1'b0);
        send_tick();
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin rl = 0; cl = 0; on_f = 1;   off_f = 1;   ud = 1; end
                1: begin rl = 1; cl = 1; on_f = 255; off_f = 255; ud = 0; end
                2: begin rl = 0; cl = 1; on_f = 1;   off_f = 255; ud = 1; end
                3: begin rl = 1; cl = 0; on_f = 255; off_f = 1;   ud = 0; end
                4: begin rl = 1; cl = 1; on_f = 0;   off_f = 3;   ud = 0; end
                5: begin rl = 0; cl = 0; on_f = 2;   off_f = 0;   ud = 1; end
                default: begin
                    rl = 1'($urandom_range(0, 1));
                    cl = 1'($urandom_range(0, 1));
                    ud = 1'($urandom_range(0, 1));
                    on_f  = ($urandom_range(0, 4) == 0) ? 8'($urandom())
                                                        : 8'($urandom_range(0, 3));
                    off_f = ($urandom_range(0, 4) == 0) ? 8'($urandom())
                                                        : 8'($urandom_range(0, 3));
                end
            endcase
            program_config(rl, cl, on_f, off_f, ud);

            // first phase runs with no idling at all
            tx_gap_pct   = (phase == 0) ? 0 : $urandom_range(5, 40);
            rx_stall_pct = (phase == 0) ? 0 : $urandom_range(5, 40);
            if (phase == 2) hold_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) drain();
                send_random_item();
            end
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
